### design/hst_pkg.sv
// Shared constants and types for the heard station table.
package hst_pkg;

   localparam int ENTRIES    = 32;
   localparam int IFACE_BITS = 4;

   localparam int KIND_W   = 1;
   localparam int IFACE_W  = 4;
   localparam int ADDR_W   = 56;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int POS_W    = 5;
   localparam int SLOT_W   = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int RANK_W   = $clog2(ENTRIES);
   localparam int TABLES   = 2;
   localparam int MEM_AW   = KIND_W + SLOT_W;
   localparam int MEM_DEPTH = TABLES * ENTRIES;

   localparam int REQ_BITS   = IFACE_W + ADDR_W + TIME_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 1 + 1 + POS_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ADDR_W-1:0] SSID_MASK = ADDR_W'(56'h1E);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_INSERT,
      ST_RESULT
   } hst_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]     address;
      logic [IFACE_BITS-1:0] iface;
      logic [COUNT_W-1:0]    count;
      logic [TIME_W-1:0]     heard;
      logic [RANK_W-1:0]     rank;
   } hst_entry_type;

   function automatic logic addr_match(input logic [ADDR_W-1:0] a,
                                       input logic [ADDR_W-1:0] b);
      logic [ADDR_W-1:0] x;
      x = a ^ b;
      return (x[ADDR_W-1:8] == '0) && ((x & SSID_MASK) == '0);
   endfunction

endpackage

### design/heard_station_table.sv
// Heard station table: two move-to-front tables held in one synchronous memory.
// Each item takes a search pass over the chosen table, then a rank update pass over
// memory on a hit or on a new entry in a table that is not empty; a new entry is then
// written at the end of the table, and a new item is dropped when the table is full.
// One item is worked on at a time; the next is taken in the cycle after the result is loaded.
// Synchronous reset clears both fill counts; the memory needs no clearing pass.
module heard_station_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // iface_id [3:0], station_address [59:4], time_now [91:60], zero fill
   input  logic [hst_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // hit [0], dropped [1], position [6:2], packet_count [38:7], zero fill
   output logic [hst_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hst_pkg::*;

   hst_state_type state_ff, state_in;

   hst_entry_type table_mem [MEM_DEPTH];
   hst_entry_type rd_data_ff;
   hst_entry_type mem_wdata;
   logic [MEM_AW-1:0] mem_raddr, mem_waddr;
   logic mem_we;

   logic [CNT_W-1:0] fill_ff [TABLES];
   logic [CNT_W-1:0] fill_in [TABLES];
   logic [CNT_W-1:0] cur_fill;

   logic                  kind_ff, kind_in;
   logic [IFACE_BITS-1:0] iface_ff, iface_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [TIME_W-1:0]     now_ff, now_in;

   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;

   logic              found_ff, found_in;
   logic [RANK_W-1:0] best_rank_ff, best_rank_in;
   logic [SLOT_W-1:0] found_slot_ff, found_slot_in;

   logic               res_hit_ff, res_hit_in;
   logic               res_drop_ff, res_drop_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic match;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff[0]   <= fill_in[0];
         fill_ff[1]   <= fill_in[1];
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      iface_ff      <= iface_in;
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      best_rank_ff  <= best_rank_in;
      found_slot_ff <= found_slot_in;
      res_hit_ff    <= res_hit_in;
      res_drop_ff   <= res_drop_in;
      res_count_ff  <= res_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign cur_fill = fill_ff[kind_ff];
   assign match = (rd_data_ff.iface == iface_ff) && addr_match(rd_data_ff.address, addr_ff);

   always_comb begin
      state_in      = state_ff;
      fill_in[0]    = fill_ff[0];
      fill_in[1]    = fill_ff[1];
      kind_in       = kind_ff;
      iface_in      = iface_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_rank_in  = best_rank_ff;
      found_slot_in = found_slot_ff;
      res_hit_in    = res_hit_ff;
      res_drop_in   = res_drop_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      req_tready    = 1'b0;
      mem_raddr     = {kind_ff, rd_idx_ff[SLOT_W-1:0]};
      mem_waddr     = {kind_ff, pend_idx_ff};
      mem_we        = 1'b0;
      mem_wdata     = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in      = req_tuser;
               iface_in     = req_tdata[IFACE_BITS-1:0];
               addr_in      = req_tdata[IFACE_W +: ADDR_W];
               now_in       = req_tdata[IFACE_W + ADDR_W +: TIME_W];
               rd_idx_in    = '0;
               found_in     = 1'b0;
               best_rank_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff != cur_fill) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[SLOT_W-1:0];
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
            end
            if (pend_ff && match && (!found_ff || rd_data_ff.rank < best_rank_ff)) begin
               found_in      = 1'b1;
               best_rank_in  = rd_data_ff.rank;
               found_slot_in = pend_idx_ff;
            end
            if (!pend_ff && rd_idx_ff == cur_fill) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rd_idx_in = '0;
            res_hit_in = found_ff;
            res_drop_in = 1'b0;
            if (found_ff) begin
               state_in = ST_UPDATE;
            end else if (cur_fill == CNT_W'(ENTRIES)) begin
               res_drop_in  = 1'b1;
               res_count_in = '0;
               state_in     = ST_RESULT;
            end else if (cur_fill == '0) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (rd_idx_ff != cur_fill) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[SLOT_W-1:0];
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
               if (!found_ff) begin
                  mem_wdata.rank = rd_data_ff.rank + RANK_W'(1);
               end else if (pend_idx_ff == found_slot_ff) begin
                  mem_wdata.rank  = '0;
                  mem_wdata.count = rd_data_ff.count + COUNT_W'(1);
                  mem_wdata.heard = now_ff;
                  res_count_in    = rd_data_ff.count + COUNT_W'(1);
               end else if (rd_data_ff.rank < best_rank_ff) begin
                  mem_wdata.rank = rd_data_ff.rank + RANK_W'(1);
               end
            end
            if (!pend_ff && rd_idx_ff == cur_fill) begin
               state_in = found_ff ? ST_RESULT : ST_INSERT;
            end
         end
         ST_INSERT: begin
            mem_we            = 1'b1;
            mem_waddr         = {kind_ff, cur_fill[SLOT_W-1:0]};
            mem_wdata.address = addr_ff;
            mem_wdata.iface   = iface_ff;
            mem_wdata.count   = COUNT_W'(1);
            mem_wdata.heard   = now_ff;
            mem_wdata.rank    = '0;
            fill_in[kind_ff]  = cur_fill + CNT_W'(1);
            res_count_in      = COUNT_W'(1);
            state_in          = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_count_ff,
                                           found_ff ? POS_W'(best_rank_ff) : POS_W'(0),
                                           res_drop_ff, res_hit_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/hst_checker.sv
// Port-level checks for the heard station table, bound to the top level.
module hst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [hst_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result item changed while stalled.");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("Result item is both a hit and dropped.");

   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[2 +: POS_W + COUNT_W] == '0)
      else $error("Dropped item carries a position or count.");

   a_new_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] && !rsp_tdata[1] |->
         rsp_tdata[2 +: POS_W] == '0 && rsp_tdata[2 + POS_W +: COUNT_W] == COUNT_W'(1))
      else $error("New entry result is not position zero with count one.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Item accepted while the previous one was still in work.");

endmodule

bind heard_station_table hst_checker u_hst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/tb_heard_station_table.sv
// Self-checking testbench for the heard station table: random and directed items, scoreboarded.
`timescale 1ns / 1ps

module tb_heard_station_table;
   import hst_pkg::*;

   localparam int RANDOM_ITEMS = 1680;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic                 kind;
      logic [IFACE_W-1:0]   iface;
      logic [ADDR_W-1:0]    address;
      logic [TIME_W-1:0]    now;
      int                   phase;
      bit                   hold;
   } station_event_type;

   typedef struct {
      logic               hit;
      logic               dropped;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] packet_count;
   } station_report_type;

   typedef struct {
      logic [IFACE_W-1:0] iface;
      logic [ADDR_W-1:0]  address;
   } station_id_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // iface_id [3:0], station_address [59:4], time_now [91:60], zero fill
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // kind
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // hit [0], dropped [1], position [6:2], packet_count [38:7], zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   station_event_type  pending_events[$];
   station_report_type due_reports[$];
   station_event_type  on_bus;
   int                 phase = 0;
   int                 errors = 0;

   // Shadow copy of both tables.
   bit                 stn_valid [TABLES][ENTRIES];
   logic [ADDR_W-1:0]  stn_address [TABLES][ENTRIES];
   logic [IFACE_W-1:0] stn_iface [TABLES][ENTRIES];
   logic [COUNT_W-1:0] stn_count [TABLES][ENTRIES];
   int                 stn_rank [TABLES][ENTRIES];
   int                 stn_fill [TABLES];

   heard_station_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_heard_station_table: FAIL");
      $finish;
   end

   function automatic bit same_station(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
      logic [ADDR_W-1:0] diff;
      diff = a ^ b;
      return diff[ADDR_W-1:8] == '0 && diff[4:1] == 4'b0000;
   endfunction

   function automatic station_report_type log_station(station_event_type ev);
      station_report_type rep;
      int                 t;
      int                 found;
      int                 best;
      t = int'(ev.kind);
      found = -1;
      best = ENTRIES + 1;
      rep = '{hit: 1'b0, dropped: 1'b0, position: '0, packet_count: '0};
      for (int s = 0; s < ENTRIES; s++) begin
         if (stn_valid[t][s] && stn_iface[t][s] == ev.iface &&
             same_station(stn_address[t][s], ev.address) && stn_rank[t][s] < best) begin
            best = stn_rank[t][s];
            found = s;
         end
      end
      if (found >= 0) begin
         for (int s = 0; s < ENTRIES; s++) begin
            if (stn_valid[t][s] && stn_rank[t][s] < best) stn_rank[t][s]++;
         end
         stn_rank[t][found] = 0;
         stn_count[t][found] = stn_count[t][found] + 1'b1;
         rep.hit = 1'b1;
         rep.position = POS_W'(best);
         rep.packet_count = stn_count[t][found];
      end else if (stn_fill[t] >= ENTRIES) begin
         rep.dropped = 1'b1;
      end else begin
         for (int s = 0; s < ENTRIES; s++) begin
            if (stn_valid[t][s]) stn_rank[t][s]++;
         end
         stn_valid[t][stn_fill[t]] = 1'b1;
         stn_address[t][stn_fill[t]] = ev.address;
         stn_iface[t][stn_fill[t]] = ev.iface;
         stn_count[t][stn_fill[t]] = 1;
         stn_rank[t][stn_fill[t]] = 0;
         stn_fill[t]++;
         rep.packet_count = 1;
      end
      return rep;
   endfunction

   function automatic int sender_idle_pct(int ph);
      return ph == 0 ? 20 : (ph == 1 ? 56 : 0);
   endfunction

   function automatic int receiver_idle_pct(int ph);
      return ph == 0 ? 56 : (ph == 1 ? 20 : 0);
   endfunction

   // Sender: predicts each accepted item, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) due_reports.push_back(log_station(on_bus));
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 &&
                !(pending_events[0].hold && due_reports.size() != 0) &&
                $urandom_range(99) >= sender_idle_pct(pending_events[0].phase)) begin
               on_bus = pending_events.pop_front();
               phase <= on_bus.phase;
               req_tvalid <= 1'b1;
               req_tuser <= on_bus.kind;
               req_tdata <= REQ_DATA_W'({on_bus.now, on_bus.address, on_bus.iface});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure and field-by-field comparison.
   always @(posedge clock) begin
      station_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= receiver_idle_pct(phase);
         if (rsp_tvalid && rsp_tready) begin
            if (due_reports.size() == 0) begin
               $error("unexpected result item 0x%h", rsp_tdata);
               errors++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_tdata[0] !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[1] !== want.dropped) begin
                  $error("dropped: expected %0d, got %0d", want.dropped, rsp_tdata[1]);
                  errors++;
               end
               if (rsp_tdata[6:2] !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_tdata[6:2]);
                  errors++;
               end
               if (rsp_tdata[38:7] !== want.packet_count) begin
                  $error("packet_count: expected %0d, got %0d",
                         want.packet_count, rsp_tdata[38:7]);
                  errors++;
               end
            end
         end
      end
   end

   task automatic add_event(logic kind, logic [IFACE_W-1:0] iface,
                            logic [ADDR_W-1:0] address, logic [TIME_W-1:0] now,
                            int ph, bit hold);
      station_event_type ev;
      ev.kind = kind;
      ev.iface = iface;
      ev.address = address;
      ev.now = now;
      ev.phase = ph;
      ev.hold = hold;
      pending_events.push_back(ev);
   endtask

   initial begin
      station_id_type    heard [TABLES][$];
      station_id_type    id;
      logic [63:0]       wide;
      logic              kind;
      int                ph;
      int                last_ph;
      logic [ADDR_W-1:0] all_ones;
      all_ones = '1;
      for (int t = 0; t < TABLES; t++) begin
         stn_fill[t] = 0;
         for (int s = 0; s < ENTRIES; s++) stn_valid[t][s] = 1'b0;
      end

      // Directed: extremes, hit at the front, address matching rules, both tables.
      add_event(1'b0, 4'd0, '0, 32'd0, 0, 0);
      add_event(1'b0, 4'd0, '0, 32'd5, 0, 0);
      add_event(1'b0, 4'hF, all_ones, 32'hFFFF_FFFF, 0, 0);
      add_event(1'b0, 4'd0, 56'hE1, 32'd7, 0, 0);
      add_event(1'b0, 4'd0, 56'h02, 32'd8, 0, 0);
      add_event(1'b0, 4'd0, 56'h10, 32'd9, 0, 0);
      add_event(1'b0, 4'd1, '0, 32'd10, 0, 0);
      add_event(1'b0, 4'd0, 56'h100, 32'd11, 0, 0);
      add_event(1'b0, 4'd0, 56'h80_0000_0000_0000, 32'd12, 0, 0);
      add_event(1'b0, 4'hF, all_ones ^ 56'hE1, 32'd13, 0, 0);
      add_event(1'b0, 4'hF, all_ones ^ 56'h08, 32'd14, 0, 0);
      add_event(1'b1, 4'hF, all_ones, 32'hFFFF_FFFF, 0, 0);
      add_event(1'b1, 4'hF, all_ones, 32'd0, 0, 0);
      add_event(1'b1, 4'd0, '0, 32'd1, 0, 0);
      add_event(1'b1, 4'hF, all_ones ^ 56'h20, 32'd2, 0, 0);
      add_event(1'b0, 4'd0, '0, 32'd20, 0, 0);
      add_event(1'b0, 4'd0, 56'h100, 32'd21, 0, 0);

      // Random: mostly revisits of stations already heard, so both tables fill
      // and then see hits at every depth together with dropped newcomers.
      last_ph = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         ph = (i * 3) / RANDOM_ITEMS;
         kind = 1'($urandom_range(1));
         if (heard[kind].size() == 0 || $urandom_range(99) <
             (heard[kind].size() < ENTRIES ? 35 : (heard[kind].size() < ENTRIES + 8 ? 8 : 0))) begin
            wide = {$urandom, $urandom};
            id.iface = IFACE_W'($urandom_range(15));
            id.address = wide[ADDR_W-1:0];
            heard[kind].push_back(id);
         end else begin
            id = heard[kind][$urandom_range(heard[kind].size() - 1)];
            // Bits outside the SSID field of the last byte are not compared.
            id.address = id.address ^ ADDR_W'($urandom_range(255) & 8'hE1);
         end
         add_event(kind, id.iface, id.address, $urandom, ph, ph != last_ph);
         last_ph = ph;
      end

      while (pending_events.size() != 0 || req_tvalid || due_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_heard_station_table: PASS");
      end else begin
         $display("tb_heard_station_table: FAIL");
      end
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

### sim.f
design/hst_pkg.sv
design/heard_station_table.sv
design/hst_checker.sv
sim/tb_heard_station_table.sv
